[design/ham_pkg.sv]
// ----------------------------------------------------------------------------
// ham_pkg - shared types and constants of the hysteresis alarm monitor
// Field widths, request codes, channel side codes and the queue entry.
// ----------------------------------------------------------------------------
package ham_pkg;

	// field widths
	localparam int VALUE_BITS   = 16;
	localparam int COUNT_BITS   = 16;
	localparam int CHAN_BITS    = 4;
	localparam int CHANNELS_DEF = 16;
	localparam int QUEUE_DEPTH  = 4;

	// stream widths: data fields packed from bit 0, padded to whole bytes
	localparam int IN_FIELDS_W  = CHAN_BITS + 3 * VALUE_BITS + 2 * COUNT_BITS;
	localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W  = 8;
	localparam int IN_TUSER_W   = 2;

	// request kinds
	typedef enum logic [1:0] {
		ACT_SAMPLE  = 2'd0,
		ACT_ALLOC   = 2'd1,
		ACT_RELEASE = 2'd2,
		ACT_QUERY   = 2'd3
	} action_t;

	// side of the hysteresis band a channel last saw
	typedef enum logic [1:0] {
		SIDE_ALARM  = 2'd0,
		SIDE_RESUME = 2'd1,
		SIDE_NONE   = 2'd2
	} side_t;

	// classified request handed from front to back
	typedef struct packed {
		action_t                       act;
		logic [CHAN_BITS-1:0]          ch;
		logic                          ch_ok;
		logic signed [VALUE_BITS-1:0]  sample;
		logic signed [VALUE_BITS-1:0]  trip_lvl;
		logic [COUNT_BITS-1:0]         trip_hold;
		logic signed [VALUE_BITS-1:0]  rec_lvl;
		logic [COUNT_BITS-1:0]         rec_hold;
	} req_t;

	// result of one request
	typedef struct packed {
		logic                 cleared;
		logic                 raised;
		logic                 active;
		logic                 ok;
		logic [CHAN_BITS-1:0] ch;
	} rsp_t;

endpackage

[design/ham_front.sv]
// ----------------------------------------------------------------------------
// ham_front - request intake
// Unpacks the input stream, decodes the request kind and range-checks the
// channel before the request enters the queue.
// ----------------------------------------------------------------------------
module ham_front #(
	parameter int CHANNELS = ham_pkg::CHANNELS_DEF
) (
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// channel, sample_value, alarm_threshold, alarm_count,
	// resume_threshold, resume_count, zero pad
	input  logic [ham_pkg::IN_TDATA_W-1:0] s_tdata,
	// action
	input  logic [ham_pkg::IN_TUSER_W-1:0] s_tuser,
	output logic                           req_valid,
	input  logic                           req_ready,
	output ham_pkg::req_t                  req
);
	import ham_pkg::*;

	localparam int O_SMP = CHAN_BITS;
	localparam int O_TL  = O_SMP + VALUE_BITS;
	localparam int O_TH  = O_TL + VALUE_BITS;
	localparam int O_RL  = O_TH + COUNT_BITS;
	localparam int O_RH  = O_RL + VALUE_BITS;

	logic [CHAN_BITS-1:0] ch;

	assign s_tready  = req_ready;
	assign req_valid = s_tvalid;
	assign ch        = s_tdata[CHAN_BITS-1:0];

	// classify the request
	always_comb begin
		req.act       = action_t'(s_tuser);
		req.ch        = ch;
		req.ch_ok     = (32'(ch) < CHANNELS);
		req.sample    = s_tdata[O_SMP +: VALUE_BITS];
		req.trip_lvl  = s_tdata[O_TL +: VALUE_BITS];
		req.trip_hold = s_tdata[O_TH +: COUNT_BITS];
		req.rec_lvl   = s_tdata[O_RL +: VALUE_BITS];
		req.rec_hold  = s_tdata[O_RH +: COUNT_BITS];
	end

endmodule

[design/ham_queue.sv]
// ----------------------------------------------------------------------------
// ham_queue - request queue
// Short FIFO between intake and execution so each side stalls on its own.
// ----------------------------------------------------------------------------
module ham_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	output logic          wr_ready,
	input  ham_pkg::req_t wr_req,
	output logic          rd_valid,
	input  logic          rd_pop,
	output ham_pkg::req_t rd_req
);
	import ham_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	req_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push;
	logic             pop;

	assign wr_ready = (cnt_q != CNT_W'(QUEUE_DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_pop && rd_valid;
	assign rd_req   = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_req;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[design/ham_back.sv]
// ----------------------------------------------------------------------------
// ham_back - request execution
// Holds the per-channel table, runs allocate, release, query and the
// hysteresis/persistence update, and registers the result for the stream.
// ----------------------------------------------------------------------------
module ham_back #(
	parameter int CHANNELS = ham_pkg::CHANNELS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            running,
	input  logic                            req_valid,
	output logic                            req_pop,
	input  ham_pkg::req_t                   req,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [ham_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import ham_pkg::*;

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	// channel table
	logic [CHANNELS-1:0]          in_use_q;
	logic [CHANNELS-1:0]          alarm_q;
	logic signed [VALUE_BITS-1:0] trip_lvl_q  [CHANNELS];
	logic [COUNT_BITS-1:0]        trip_hold_q [CHANNELS];
	logic signed [VALUE_BITS-1:0] rec_lvl_q   [CHANNELS];
	logic [COUNT_BITS-1:0]        rec_hold_q  [CHANNELS];
	logic [COUNT_BITS-1:0]        cnt_q       [CHANNELS];
	side_t                        side_q      [CHANNELS];

	// output register
	logic  out_valid_q;
	rsp_t  rsp_q;

	logic                         pop;
	logic [IDX_W-1:0]             idx;
	logic                         sel_used;
	logic [IDX_W-1:0]             free_idx;
	logic                         free_found;
	logic signed [VALUE_BITS-1:0] t_lvl;
	logic signed [VALUE_BITS-1:0] r_lvl;
	logic                         on_alarm;
	logic                         on_resume;
	side_t                        side_new;
	logic                         counting;
	logic [COUNT_BITS-1:0]        need;
	logic [COUNT_BITS-1:0]        cnt_base;
	logic [COUNT_BITS-1:0]        cnt_inc;
	logic                         fire;
	logic                         smp_upd;
	logic                         flag_new;
	rsp_t                         rsp;

	assign pop      = req_valid && (!out_valid_q || m_tready);
	assign req_pop  = pop;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = rsp_q;

	assign idx      = IDX_W'(req.ch);
	assign sel_used = req.ch_ok && in_use_q[idx];
	assign t_lvl    = trip_lvl_q[idx];
	assign r_lvl    = rec_lvl_q[idx];

	// lowest free channel
	always_comb begin
		free_idx   = '0;
		free_found = 1'b0;
		for (int c = CHANNELS - 1; c >= 0; c--) begin
			if (!in_use_q[c]) begin
				free_idx   = IDX_W'(c);
				free_found = 1'b1;
			end
		end
	end

	// side of the band; direction follows the larger threshold
	always_comb begin
		on_alarm  = 1'b0;
		on_resume = 1'b0;
		if (t_lvl > r_lvl) begin
			on_alarm  = (req.sample >= t_lvl);
			on_resume = !on_alarm && (req.sample <= r_lvl);
		end else if (t_lvl < r_lvl) begin
			on_alarm  = (req.sample <= t_lvl);
			on_resume = !on_alarm && (req.sample >= r_lvl);
		end
	end

	// persistence counter
	always_comb begin
		side_new = on_alarm ? SIDE_ALARM : SIDE_RESUME;
		counting = on_alarm ? !alarm_q[idx] : alarm_q[idx];
		need     = on_alarm ? trip_hold_q[idx] : rec_hold_q[idx];
		cnt_base = (side_q[idx] != side_new) ? '0 : cnt_q[idx];
		cnt_inc  = (counting && cnt_base != CNT_MAX) ? cnt_base + 1'b1 : cnt_base;
		fire     = counting && (need != '0) && (cnt_inc == need);
		smp_upd  = (req.act == ACT_SAMPLE) && sel_used && running && (on_alarm || on_resume);
		flag_new = fire ? on_alarm : alarm_q[idx];
	end

	// result of the request
	always_comb begin
		rsp = '0;
		rsp.ch = req.ch;
		case (req.act)
			ACT_ALLOC: begin
				rsp.ch = free_found ? CHAN_BITS'(free_idx) : '0;
				rsp.ok = free_found;
			end
			ACT_RELEASE: begin
				rsp.ok = sel_used;
			end
			ACT_QUERY: begin
				rsp.ok     = sel_used;
				rsp.active = req.ch_ok && alarm_q[idx];
			end
			ACT_SAMPLE: begin
				if (sel_used) begin
					rsp.ok      = running;
					rsp.active  = smp_upd ? flag_new : alarm_q[idx];
					rsp.raised  = smp_upd && fire && on_alarm;
					rsp.cleared = smp_upd && fire && on_resume;
				end
			end
			default: rsp = '0;
		endcase
	end

	// control part of the table and the output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q    <= '0;
			alarm_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				case (req.act)
					ACT_ALLOC: begin
						if (free_found) begin
							in_use_q[free_idx] <= 1'b1;
							alarm_q[free_idx]  <= 1'b0;
						end
					end
					ACT_RELEASE: begin
						if (sel_used) begin
							in_use_q[idx] <= 1'b0;
							alarm_q[idx]  <= 1'b0;
						end
					end
					ACT_SAMPLE: begin
						if (smp_upd) begin
							alarm_q[idx] <= flag_new;
						end
					end
					default: ;
				endcase
			end
		end
	end

	// payload part of the table and the result data
	always_ff @(posedge clk) begin
		if (pop) begin
			rsp_q <= rsp;
			case (req.act)
				ACT_ALLOC: begin
					if (free_found) begin
						trip_lvl_q[free_idx]  <= req.trip_lvl;
						trip_hold_q[free_idx] <= req.trip_hold;
						rec_lvl_q[free_idx]   <= req.rec_lvl;
						rec_hold_q[free_idx]  <= req.rec_hold;
						cnt_q[free_idx]       <= '0;
						side_q[free_idx]      <= SIDE_NONE;
					end
				end
				ACT_SAMPLE: begin
					if (smp_upd) begin
						cnt_q[idx]  <= fire ? '0 : cnt_inc;
						side_q[idx] <= side_new;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

[design/hysteresis_alarm_monitor_unit.sv]
// A result passes through the queue and the output register after its request is accepted.
// One request per clock while the result stream is not stalled; the channel table update of the back
// end completes in the cycle the request leaves the queue.
// A four-entry queue absorbs output stalls before s_tready drops.
// Reset (arst_n low) frees all channels, clears alarms, stops evaluation
// and empties the queue and output register; no clearing pass follows.
// ----------------------------------------------------------------------------
// hysteresis_alarm_monitor_unit - multi-channel alarm qualifier
// Intake and classification, request queue, and channel table execution.
// ----------------------------------------------------------------------------
module hysteresis_alarm_monitor_unit #(
	parameter int CHANNELS = ham_pkg::CHANNELS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic                            cfg_wdata,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// channel, sample_value, alarm_threshold, alarm_count,
	// resume_threshold, resume_count, zero pad
	input  logic [ham_pkg::IN_TDATA_W-1:0]  s_tdata,
	// action
	input  logic [ham_pkg::IN_TUSER_W-1:0]  s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// result_channel, ok, alarm_active, raised, cleared
	output logic [ham_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import ham_pkg::*;

	logic running_q;
	logic fr_valid;
	logic fr_ready;
	req_t fr_req;
	logic q_valid;
	logic q_pop;
	req_t q_req;

	// running register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
		end else if (cfg_we) begin
			running_q <= cfg_wdata;
		end
	end

	ham_front #(.CHANNELS(CHANNELS)) u_front (
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.req_valid (fr_valid),
		.req_ready (fr_ready),
		.req       (fr_req)
	);

	ham_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fr_valid),
		.wr_ready (fr_ready),
		.wr_req   (fr_req),
		.rd_valid (q_valid),
		.rd_pop   (q_pop),
		.rd_req   (q_req)
	);

	ham_back #(.CHANNELS(CHANNELS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.running   (running_q),
		.req_valid (q_valid),
		.req_pop   (q_pop),
		.req       (q_req),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

[design/ham_checker.sv]
// ----------------------------------------------------------------------------
// ham_checker - port-level checks of the alarm monitor
// Watches the result stream for held results and consistent alarm flags.
// ----------------------------------------------------------------------------
module ham_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [ham_pkg::OUT_TDATA_W-1:0] m_tdata
);
	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// a raise and a clear never come together
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[6] && m_tdata[7]))
		else $error("raised and cleared both set");

	// a raise leaves the alarm on and reports success
	a_raise: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[6] |-> m_tdata[5] && m_tdata[4])
		else $error("raise without active alarm");

	// a clear leaves the alarm off and reports success
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[7] |-> !m_tdata[5] && m_tdata[4])
		else $error("clear with alarm still active");

endmodule

bind hysteresis_alarm_monitor_unit ham_checker u_ham_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

[tb/sv/hysteresis_alarm_monitor_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hysteresis_alarm_monitor_unit_tb - self-checking bench for the alarm monitor
// Drives allocate, release, query and sample requests over the input stream
// under random stalls on both sides. A scoreboard object keeps its own copy of
// the channel table and the running bit, and checks every result in order.
// ----------------------------------------------------------------------------
module hysteresis_alarm_monitor_unit_tb;
	import ham_pkg::*;

	localparam int N_CH = CHANNELS_DEF;

	// channel table predictor and in-order result checker
	class alarm_scoreboard;
		bit                           running;
		bit                           in_use[N_CH];
		logic signed [VALUE_BITS-1:0] trip_lvl[N_CH];
		logic signed [VALUE_BITS-1:0] rec_lvl[N_CH];
		logic [COUNT_BITS-1:0]        trip_hold[N_CH];
		logic [COUNT_BITS-1:0]        rec_hold[N_CH];
		logic [COUNT_BITS-1:0]        hold_cnt[N_CH];
		bit                           alarm[N_CH];
		side_t                        side[N_CH];
		rsp_t                         pending_rsp[$];
		int                           errors;

		function new();
			running = 1'b0;
			errors = 0;
			for (int c = 0; c < N_CH; c++) begin
				clear_channel(c);
			end
		endfunction

		function void clear_channel(int c);
			in_use[c] = 1'b0;
			trip_lvl[c] = '0;
			rec_lvl[c] = '0;
			trip_hold[c] = '0;
			rec_hold[c] = '0;
			hold_cnt[c] = '0;
			alarm[c] = 1'b0;
			side[c] = SIDE_NONE;
		endfunction

		// step the persistence counter; returns 1 when the hold count is met
		function bit advance(int c, side_t s, bit counting, logic [COUNT_BITS-1:0] need);
			bit fire;
			fire = 1'b0;
			if (side[c] != s) begin
				hold_cnt[c] = '0;
			end
			if (counting) begin
				if (hold_cnt[c] != '1) begin
					hold_cnt[c] = hold_cnt[c] + 1'b1;
				end
				if (need != '0 && hold_cnt[c] == need) begin
					fire = 1'b1;
					hold_cnt[c] = '0;
				end
			end
			side[c] = s;
			return fire;
		endfunction

		// accepted request: update the table and queue the expected result
		function void note_request(action_t act, logic [CHAN_BITS-1:0] ch,
				logic signed [VALUE_BITS-1:0] smp, logic signed [VALUE_BITS-1:0] trip,
				logic [COUNT_BITS-1:0] trip_n, logic signed [VALUE_BITS-1:0] rec,
				logic [COUNT_BITS-1:0] rec_n);
			rsp_t rsp;
			bit   on_alarm;
			bit   on_resume;
			rsp = '0;
			rsp.ch = ch;
			on_alarm = 1'b0;
			on_resume = 1'b0;
			case (act)
				ACT_ALLOC: begin
					rsp.ch = '0;
					for (int c = 0; c < N_CH; c++) begin
						if (!in_use[c]) begin
							clear_channel(c);
							in_use[c] = 1'b1;
							trip_lvl[c] = trip;
							trip_hold[c] = trip_n;
							rec_lvl[c] = rec;
							rec_hold[c] = rec_n;
							rsp.ch = c[CHAN_BITS-1:0];
							rsp.ok = 1'b1;
							break;
						end
					end
				end
				ACT_RELEASE: begin
					if (in_use[ch]) begin
						clear_channel(ch);
						rsp.ok = 1'b1;
					end
				end
				ACT_QUERY: begin
					rsp.ok = in_use[ch];
					rsp.active = alarm[ch];
				end
				default: begin
					if (in_use[ch]) begin
						if (running) begin
							rsp.ok = 1'b1;
							// direction follows the greater threshold
							if (trip_lvl[ch] > rec_lvl[ch]) begin
								on_alarm = smp >= trip_lvl[ch];
								on_resume = !on_alarm && smp <= rec_lvl[ch];
							end else if (trip_lvl[ch] < rec_lvl[ch]) begin
								on_alarm = smp <= trip_lvl[ch];
								on_resume = !on_alarm && smp >= rec_lvl[ch];
							end
							if (on_alarm) begin
								if (advance(ch, SIDE_ALARM, !alarm[ch], trip_hold[ch])) begin
									alarm[ch] = 1'b1;
									rsp.raised = 1'b1;
								end
							end else if (on_resume) begin
								if (advance(ch, SIDE_RESUME, alarm[ch], rec_hold[ch])) begin
									alarm[ch] = 1'b0;
									rsp.cleared = 1'b1;
								end
							end
						end
						rsp.active = alarm[ch];
					end
				end
			endcase
			pending_rsp.push_back(rsp);
		endfunction

		task report(string msg);
			$display("%0t ns: mismatch: %s", $time, msg);
			errors++;
		endtask

		// compare one result against the oldest expectation
		task check_result(logic [OUT_TDATA_W-1:0] data);
			rsp_t got;
			rsp_t exp;
			got = rsp_t'(data);
			if (pending_rsp.size() == 0) begin
				report($sformatf("unexpected result %h", data));
			end else begin
				exp = pending_rsp.pop_front();
				if (got.ch !== exp.ch)
					report($sformatf("result_channel %0d, expected %0d", got.ch, exp.ch));
				if (got.ok !== exp.ok)
					report($sformatf("ok %b, expected %b (ch %0d)", got.ok, exp.ok, exp.ch));
				if (got.active !== exp.active)
					report($sformatf("alarm_active %b, expected %b (ch %0d)",
						got.active, exp.active, exp.ch));
				if (got.raised !== exp.raised)
					report($sformatf("raised %b, expected %b (ch %0d)",
						got.raised, exp.raised, exp.ch));
				if (got.cleared !== exp.cleared)
					report($sformatf("cleared %b, expected %b (ch %0d)",
						got.cleared, exp.cleared, exp.ch));
			end
		endtask

		// random channel among those allocated, -1 if none
		function int pick_used();
			int used[$];
			for (int c = 0; c < N_CH; c++) begin
				if (in_use[c]) used.push_back(c);
			end
			if (used.size() == 0) return -1;
			return used[$urandom_range(used.size() - 1)];
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic                   cfg_wdata = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic [IN_TUSER_W-1:0]  s_tuser = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	int send_pct = 27;
	int recv_pct = 75;

	alarm_scoreboard sb;

	hysteresis_alarm_monitor_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// result side backpressure
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_pct);
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_result(m_tdata);
		end
	end

	// one request: random gaps, then hold until accepted
	task automatic send_request(action_t act, logic [CHAN_BITS-1:0] ch,
			logic [VALUE_BITS-1:0] smp, logic [VALUE_BITS-1:0] trip,
			logic [COUNT_BITS-1:0] trip_n, logic [VALUE_BITS-1:0] rec,
			logic [COUNT_BITS-1:0] rec_n);
		@(negedge clk);
		while ($urandom_range(99) < send_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {4'b0, rec_n, rec, trip_n, trip, smp, ch};
		do @(posedge clk); while (!s_tready);
		sb.note_request(act, ch, smp, trip, trip_n, rec, rec_n);
	endtask

	task automatic do_sample(logic [CHAN_BITS-1:0] ch, logic [VALUE_BITS-1:0] v);
		send_request(ACT_SAMPLE, ch, v, VALUE_BITS'($urandom), COUNT_BITS'($urandom),
			VALUE_BITS'($urandom), COUNT_BITS'($urandom));
	endtask

	task automatic do_alloc(logic [VALUE_BITS-1:0] trip, logic [COUNT_BITS-1:0] trip_n,
			logic [VALUE_BITS-1:0] rec, logic [COUNT_BITS-1:0] rec_n);
		send_request(ACT_ALLOC, CHAN_BITS'($urandom), VALUE_BITS'($urandom), trip, trip_n,
			rec, rec_n);
	endtask

	task automatic do_op(action_t act, logic [CHAN_BITS-1:0] ch);
		send_request(act, ch, VALUE_BITS'($urandom), VALUE_BITS'($urandom),
			COUNT_BITS'($urandom), VALUE_BITS'($urandom), COUNT_BITS'($urandom));
	endtask

	// drop valid and wait until every result is back
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending_rsp.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_running(bit v);
		drain();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.running = v;
	endtask

	// random threshold: mostly a narrow window so samples land near it
	function automatic logic [VALUE_BITS-1:0] rand_level();
		int k;
		k = $urandom_range(9);
		if (k < 6) return VALUE_BITS'($urandom_range(200) - 100);
		if (k < 8) return VALUE_BITS'($urandom);
		return k[0] ? 16'h7fff : 16'h8000;
	endfunction

	function automatic logic [COUNT_BITS-1:0] rand_count();
		int k;
		k = $urandom_range(9);
		if (k < 7) return COUNT_BITS'($urandom_range(4));
		if (k < 9) return COUNT_BITS'($urandom_range(15));
		return COUNT_BITS'($urandom);
	endfunction

	// sample value aimed at the channel's thresholds and band
	function automatic logic [VALUE_BITS-1:0] rand_value(int ch);
		int t;
		int r;
		t = (ch < 0) ? 0 : int'(sb.trip_lvl[ch]);
		r = (ch < 0) ? 0 : int'(sb.rec_lvl[ch]);
		case ($urandom_range(7))
			0: return VALUE_BITS'(t);
			1: return VALUE_BITS'(r);
			2: return VALUE_BITS'(t + int'($urandom_range(6)) - 3);
			3: return VALUE_BITS'(r + int'($urandom_range(6)) - 3);
			4: return VALUE_BITS'((t + r) / 2);
			5: return VALUE_BITS'($urandom);
			6: return VALUE_BITS'(t + int'($urandom_range(40)) - 20);
			default: return VALUE_BITS'(r + int'($urandom_range(40)) - 20);
		endcase
	endfunction

	task automatic run_random(int n);
		int r;
		int ch;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			ch = sb.pick_used();
			if ($urandom_range(99) < 20) ch = $urandom_range(N_CH - 1);
			if (r < 12) begin
				do_alloc(rand_level(), rand_count(), rand_level(), rand_count());
			end else if (r < 20) begin
				do_op(ACT_RELEASE, CHAN_BITS'((ch < 0) ? $urandom_range(N_CH - 1) : ch));
			end else if (r < 30) begin
				do_op(ACT_QUERY, CHAN_BITS'((ch < 0) ? $urandom_range(N_CH - 1) : ch));
			end else begin
				do_sample(CHAN_BITS'((ch < 0) ? $urandom_range(N_CH - 1) : ch),
					rand_value(ch));
			end
		end
	endtask

	initial begin
		sb = new();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: evaluation stopped, unused channels
		do_sample(0, 16'd200);
		do_op(ACT_QUERY, 15);
		do_op(ACT_RELEASE, 5);
		do_alloc(16'd100, 16'd2, -16'sd100, 16'd1);
		do_sample(0, 16'd200);
		write_running(1'b1);

		// raise after two samples, band, on-side hold, clear
		do_sample(0, 16'd200);
		do_sample(0, 16'd150);
		do_sample(0, 16'd0);
		do_sample(0, 16'd100);
		do_sample(0, -16'sd100);
		do_op(ACT_QUERY, 0);

		// inverted direction at the extremes, equal thresholds, zero count
		do_alloc(16'h8000, 16'd3, 16'h7fff, 16'd0);
		do_alloc(16'd5, 16'd1, 16'd5, 16'd1);
		do_sample(2, 16'd5);
		do_sample(2, 16'h8000);
		do_alloc(16'd10, 16'd0, -16'sd10, 16'd3);
		do_sample(3, 16'd10);
		do_sample(3, 16'd10);
		do_sample(3, 16'h7fff);
		do_op(ACT_RELEASE, 0);
		do_op(ACT_QUERY, 0);
		do_sample(0, 16'd200);

		// inverted direction: raises on the third sample at the lowest value
		for (int i = 0; i < 3; i++) begin
			do_sample(1, 16'h8000);
		end
		// resume count of zero never clears
		do_sample(1, 16'h7fff);
		do_sample(1, 16'h7fff);
		do_sample(1, 16'h7fff);

		// random phases
		send_pct = 27;
		recv_pct = 75;
		run_random(350);
		write_running(1'b0);
		send_pct = 75;
		recv_pct = 27;
		run_random(100);
		write_running(1'b1);
		run_random(300);
		send_pct = 0;
		recv_pct = 0;
		run_random(300);

		drain();
		repeat (10) @(posedge clk);
		if (sb.errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// overall time limit
	initial begin
		#20_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

[hysteresis_alarm_monitor_unit.f]
design/ham_pkg.sv
design/ham_front.sv
design/ham_queue.sv
design/ham_back.sv
design/hysteresis_alarm_monitor_unit.sv
design/ham_checker.sv
tb/sv/hysteresis_alarm_monitor_unit_tb.sv
